### src/bsoc_pkg.sv
// Shared constants, types and curve tables for the battery state-of-charge block.
// Depends on nothing; every other file of the block imports it.
package bsoc_pkg;

  localparam int ADC_W     = 12;
  localparam int GAIN_W    = 14;
  localparam int OFFS_W    = 12;
  localparam int MV_W      = 15;
  localparam int PCT_W     = 7;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = ADC_W + GAIN_W;
  localparam int SUM_W     = MV_W + 2;
  localparam int SEG_W     = 5;
  localparam int DIFF_W    = 7;
  localparam int TENX_W    = 10;
  localparam int NUM_SEGS  = 20;
  localparam int PCT_STEP_SLOTS = 5;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd4096;
  localparam logic [OFFS_W-1:0] OFFS_RESET = 12'd0;
  localparam logic [MV_W-1:0]   MV_MAX     = 15'h7fff;
  localparam logic [MV_W-1:0]   MV_TOP     = 15'd4200;
  localparam logic [MV_W-1:0]   MV_BOTTOM  = 15'd3500;
  localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_EMPTY  = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_reg_t;

  typedef logic [MV_W-1:0] mv_t;

  // Voltage of curve point p, from 4200 mV at point 0 down to 3500 mV at point 20.
  function automatic mv_t curve_mv(input logic [SEG_W-1:0] p);
    mv_t r;
    case (p)
      5'd0:    r = 15'd4200;
      5'd1:    r = 15'd4150;
      5'd2:    r = 15'd4110;
      5'd3:    r = 15'd4080;
      5'd4:    r = 15'd4020;
      5'd5:    r = 15'd3980;
      5'd6:    r = 15'd3950;
      5'd7:    r = 15'd3910;
      5'd8:    r = 15'd3870;
      5'd9:    r = 15'd3850;
      5'd10:   r = 15'd3820;
      5'd11:   r = 15'd3790;
      5'd12:   r = 15'd3770;
      5'd13:   r = 15'd3740;
      5'd14:   r = 15'd3720;
      5'd15:   r = 15'd3700;
      5'd16:   r = 15'd3680;
      5'd17:   r = 15'd3650;
      5'd18:   r = 15'd3620;
      5'd19:   r = 15'd3580;
      default: r = 15'd3500;
    endcase
    return r;
  endfunction

  // Width in millivolts of segment s, which spans points s and s+1.
  function automatic logic [DIFF_W-1:0] seg_delta(input logic [SEG_W-1:0] s);
    mv_t d;
    d = curve_mv(s) - curve_mv(SEG_W'(s + 5'd1));
    return d[DIFF_W-1:0];
  endfunction

  // Percent at the lower end of segment s.
  function automatic logic [PCT_W-1:0] seg_pct_low(input logic [SEG_W-1:0] s);
    logic [PCT_W-1:0] r;
    r = 7'd95 - (PCT_W'(s) * 7'd5);
    return r;
  endfunction

endpackage

### src/bsoc_if.sv
// Valid/ready channel interfaces for the ADC input and the result output.
// Depends on bsoc_pkg for the field widths.
interface bsoc_in_if;
  import bsoc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_mv;

  modport source (output valid, output adc_mv, input ready);
  modport sink (input valid, input adc_mv, output ready);
endinterface

interface bsoc_out_if;
  import bsoc_pkg::*;
  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  battery_mv;
  logic [PCT_W-1:0] charge_percent;

  modport source (output valid, output battery_mv, output charge_percent, input ready);
  modport sink (input valid, input battery_mv, input charge_percent, output ready);
endinterface

### src/bsoc_calib.sv
// Calibration pipeline: gain multiply, then rounding, offset and saturation.
// Depends on bsoc_pkg.
module bsoc_calib (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bsoc_pkg::GAIN_W-1:0]  gain,
  input  logic [bsoc_pkg::OFFS_W-1:0]  offset,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsoc_pkg::ADC_W-1:0]   adc,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsoc_pkg::MV_W-1:0]    mv
);
  import bsoc_pkg::*;

  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod;
  logic              s2_valid;
  logic [MV_W-1:0]   s2_mv;
  logic              en1;
  logic              en2;
  logic [PROD_W:0]   rsum;
  logic [MV_W:0]     gained;
  logic [SUM_W-1:0]  sum;
  logic [MV_W-1:0]   sat;

  assign en2      = !s2_valid || out_ready;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // Battery mV = (2 * adc * gain + 2048) >> 12 = (adc * gain + 1024) >> 11.
  always_comb begin
    rsum   = {1'b0, s1_prod} + (PROD_W+1)'(1024);
    gained = rsum[PROD_W:11];
    sum    = {1'b0, gained} + {{(SUM_W-OFFS_W){offset[OFFS_W-1]}}, offset};
    if (sum[SUM_W-1]) begin
      sat = '0;
    end else if (sum[SUM_W-2]) begin
      sat = MV_MAX;
    end else begin
      sat = sum[MV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1_prod <= PROD_W'(adc) * PROD_W'(gain);
    if (en2 && s1_valid) s2_mv <= sat;
  end

  assign out_valid = s2_valid;
  assign mv        = s2_mv;

endmodule

### src/bsoc_curve.sv
// Curve pipeline: segment compares, segment select, interpolation and rounding.
// Depends on bsoc_pkg for the curve tables.
module bsoc_curve (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsoc_pkg::MV_W-1:0]    mv,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsoc_pkg::MV_W-1:0]    battery_mv,
  output logic [bsoc_pkg::PCT_W-1:0]   charge_percent
);
  import bsoc_pkg::*;

  logic                  s3_valid;
  logic [MV_W-1:0]       s3_mv;
  logic [NUM_SEGS-2:0]   s3_therm;
  logic                  s3_top;
  logic                  s3_bot;
  logic                  s4_valid;
  logic [MV_W-1:0]       s4_mv;
  logic                  s4_top;
  logic                  s4_bot;
  logic [SEG_W-1:0]      s4_idx;
  logic [DIFF_W-1:0]     s4_diff;
  logic [DIFF_W-1:0]     s4_delta;
  logic                  s5_valid;
  logic [MV_W-1:0]       s5_mv;
  logic [PCT_W-1:0]      s5_pct;
  logic                  en3;
  logic                  en4;
  logic                  en5;
  logic [NUM_SEGS-2:0]   therm;
  logic [SEG_W-1:0]      idx;
  logic [MV_W-1:0]       lo_diff;
  logic [TENX_W-1:0]     tenx;
  logic [2:0]            q;
  logic [PCT_W-1:0]      pct;

  assign en5      = !s5_valid || out_ready;
  assign en4      = !s4_valid || en5;
  assign en3      = !s3_valid || en4;
  assign in_ready = en3;

  // Bit j-1 is set when the voltage lies below interior point j; the number of
  // set bits is the index of the segment that holds the voltage.
  always_comb begin
    for (int j = 1; j < NUM_SEGS; j++) begin
      therm[j-1] = mv < curve_mv(SEG_W'(j));
    end
  end

  always_comb begin
    idx     = SEG_W'($countones(s3_therm));
    lo_diff = s3_mv - curve_mv(SEG_W'(idx + 5'd1));
  end

  // Rounded quotient (10*diff + d) / (2*d) lies in 0..5; each step k is taken
  // when 10*diff reaches d*(2k-1).
  always_comb begin
    tenx = TENX_W'(s4_diff) * TENX_W'(10);
    q    = 3'd0;
    for (int k = 1; k <= PCT_STEP_SLOTS; k++) begin
      if (tenx >= TENX_W'(s4_delta) * TENX_W'(2 * k - 1)) q = q + 3'd1;
    end
    if (s4_top) begin
      pct = PCT_FULL;
    end else if (s4_bot) begin
      pct = PCT_EMPTY;
    end else begin
      pct = seg_pct_low(s4_idx) + PCT_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (en3) s3_valid <= in_valid;
      if (en4) s4_valid <= s3_valid;
      if (en5) s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      s3_mv    <= mv;
      s3_therm <= therm;
      s3_top   <= mv >= MV_TOP;
      s3_bot   <= mv <= MV_BOTTOM;
    end
    if (en4 && s3_valid) begin
      s4_mv    <= s3_mv;
      s4_top   <= s3_top;
      s4_bot   <= s3_bot;
      s4_idx   <= idx;
      s4_diff  <= lo_diff[DIFF_W-1:0];
      s4_delta <= seg_delta(idx);
    end
    if (en5 && s4_valid) begin
      s5_mv  <= s4_mv;
      s5_pct <= pct;
    end
  end

  assign out_valid      = s5_valid;
  assign battery_mv     = s5_mv;
  assign charge_percent = s5_pct;

endmodule

### src/battery_soc_interpolator_core.sv
// Top level of the battery state-of-charge block: configuration registers and
// the calibration and curve pipelines. Depends on bsoc_pkg, bsoc_if,
// bsoc_calib and bsoc_curve.
//
// Each ADC transfer on in_ch yields exactly one result transfer on out_ch, in
// order. The block is a five-stage pipeline (gain multiply; rounding, offset
// and saturation; segment compares; segment select and offset into the
// segment; interpolation) and takes one reading every clock cycle while
// out_ch is not stalled. Every stage holds a valid bit and moves forward
// when the stage after it is empty or moving, so a stall on out_ch fills any
// bubbles first and then holds in_ch.ready low without losing or repeating a
// transfer. The result register at the end of the curve pipeline is the
// output register of out_ch. Configuration writes take effect on the next
// cycle and are meant to be made while no reading is in flight: gain_q12
// (index 0) is a Q2.12 gain, unity at 4096, and offset_mv (index 1) is a
// signed millivolt offset. The percent is interpolated on a fixed 21-point
// Li-ion curve, 100 at 4200 mV and above, 0 at 3500 mV and below, rounded
// half up.
module battery_soc_interpolator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bsoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsoc_pkg::CFG_W-1:0]      cfg_wdata,
  bsoc_in_if.sink                         in_ch,
  bsoc_out_if.source                      out_ch
);
  import bsoc_pkg::*;

  logic [GAIN_W-1:0] gain;
  logic [OFFS_W-1:0] offset;
  logic              mid_valid;
  logic              mid_ready;
  logic [MV_W-1:0]   mid_mv;

  // Configuration registers. An index that names no register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      offset <= OFFS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GAIN:   gain   <= cfg_wdata[GAIN_W-1:0];
        CFG_OFFSET: offset <= cfg_wdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stages one and two produce the calibrated, saturated battery voltage.
  bsoc_calib u_calib (
    .clk       (clk),
    .rst       (rst),
    .gain      (gain),
    .offset    (offset),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .adc       (in_ch.adc_mv),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .mv        (mid_mv)
  );

  // Stages three to five map the voltage onto the charge curve.
  bsoc_curve u_curve (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (mid_valid),
    .in_ready       (mid_ready),
    .mv             (mid_mv),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .battery_mv     (out_ch.battery_mv),
    .charge_percent (out_ch.charge_percent)
  );

endmodule
